### rtl/core/lrupr_pkg.sv
package lrupr_pkg;

  localparam int unsigned FramesDefault = 8;
  localparam int unsigned FramesMax     = 16;
  localparam int unsigned CfgW          = 4;
  localparam int unsigned PageW         = 16;
  localparam int unsigned FrameIdxW     = 3;
  localparam int unsigned CellIdxW      = 4;
  localparam int unsigned RankW         = 8;

  localparam logic [RankW-1:0] RankMax  = {RankW{1'b1}};
  localparam logic [CfgW-1:0]  CfgReset = CfgW'(3);

  typedef struct packed {
    logic [PageW-1:0] page_number;
    logic             end_of_string;
  } req_t;

  typedef struct packed {
    logic                 hit;
    logic [FrameIdxW-1:0] frame_index;
    logic                 evicted_valid;
    logic [PageW-1:0]     evicted_page;
  } rsp_t;

  // search word that walks down the cell chain
  typedef struct packed {
    logic                valid;
    logic [PageW-1:0]    page;
    logic                hit_found;
    logic [CellIdxW-1:0] hit_idx;
    logic [RankW-1:0]    hit_rank;
    logic                empty_found;
    logic [CellIdxW-1:0] empty_idx;
    logic                best_found;
    logic [CellIdxW-1:0] best_idx;
    logic [RankW-1:0]    best_rank;
    logic [PageW-1:0]    best_page;
  } tok_t;

  // update broadcast to every cell once the search word leaves the chain
  typedef struct packed {
    logic                en;
    logic                clear;
    logic                hit;
    logic [CellIdxW-1:0] idx;
    logic [RankW-1:0]    limit;
    logic                age_all;
    logic [PageW-1:0]    page;
  } upd_t;

endpackage

### rtl/core/lrupr_cell.sv
module lrupr_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_use_i,
  input  lrupr_pkg::tok_t  tok_i,
  output lrupr_pkg::tok_t  tok_o,
  input  lrupr_pkg::upd_t  upd_i
);

  localparam logic [lrupr_pkg::CellIdxW-1:0] MyIdx = lrupr_pkg::CellIdxW'(CELL_IDX);

  logic [lrupr_pkg::PageW-1:0] page_q, page_d;
  logic                        valid_q, valid_d;
  logic [lrupr_pkg::RankW-1:0] rank_q, rank_d;
  lrupr_pkg::tok_t             tok_q, tok_d;

  // search step for this frame
  always_comb begin
    tok_d = tok_i;
    if (in_use_i) begin
      if (!tok_i.hit_found && valid_q && (page_q == tok_i.page)) begin
        tok_d.hit_found = 1'b1;
        tok_d.hit_idx   = MyIdx;
        tok_d.hit_rank  = rank_q;
      end
      if (!tok_i.empty_found && !valid_q) begin
        tok_d.empty_found = 1'b1;
        tok_d.empty_idx   = MyIdx;
      end
      if (!tok_i.best_found || (rank_q > tok_i.best_rank)) begin
        tok_d.best_found = 1'b1;
        tok_d.best_idx   = MyIdx;
        tok_d.best_rank  = rank_q;
        tok_d.best_page  = page_q;
      end
    end
  end

  // frame update
  always_comb begin
    page_d  = page_q;
    valid_d = valid_q;
    rank_d  = rank_q;
    if (upd_i.clear) begin
      page_d  = '0;
      valid_d = 1'b0;
      rank_d  = '0;
    end else if (upd_i.en) begin
      if (upd_i.idx == MyIdx) begin
        rank_d = '0;
        if (!upd_i.hit) begin
          page_d  = upd_i.page;
          valid_d = 1'b1;
        end
      end else if (valid_q && (upd_i.age_all || (rank_q < upd_i.limit))
                   && (rank_q != lrupr_pkg::RankMax)) begin
        rank_d = rank_q + lrupr_pkg::RankW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_q  <= '0;
      valid_q <= 1'b0;
      rank_q  <= '0;
      tok_q   <= '0;
    end else begin
      page_q  <= page_d;
      valid_q <= valid_d;
      rank_q  <= rank_d;
      tok_q   <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

### rtl/core/lru_page_replacement.sv
// channel   ports                                   direction  handshake
// request   req_i (page_number, end_of_string)      in         start high, busy low
// result    rsp_o (hit, frame_index, evicted_*)     out        done_o, one cycle
// config    cfg_wdata_i (frames_in_use)             in         cfg_we_i high
//
// a request word enters a registered search word that moves one cell per cycle
// down the chain of FRAMES cells; the word passes tok0_q and then each cell's register,
// and done_o is registered from the last cell's output. start is taken again in the
// cycle that done_o is high, so no new item enters before the last one leaves the chain.
// reset clears all frames, ranks and the chain, and sets frames_in_use to 3.
// the receiver cannot stall: done_o lasts exactly one cycle.
module lru_page_replacement #(
  parameter int unsigned FRAMES = lrupr_pkg::FramesDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  lrupr_pkg::req_t            req_i,
  output logic                       done_o,
  output lrupr_pkg::rsp_t            rsp_o,
  input  logic                       cfg_we_i,
  input  logic [lrupr_pkg::CfgW-1:0] cfg_wdata_i
);

  logic [lrupr_pkg::CfgW-1:0] cfg_q;
  logic                       busy_q, busy_d;
  logic                       eos_q, eos_d;
  logic                       done_q, done_d;
  lrupr_pkg::rsp_t            rsp_q, rsp_d;
  lrupr_pkg::tok_t            tok0_q, tok0_d;
  lrupr_pkg::tok_t            tok [FRAMES+1];
  lrupr_pkg::tok_t            last;
  lrupr_pkg::upd_t            upd;
  logic [FRAMES-1:0]          in_use;
  logic [lrupr_pkg::CellIdxW-1:0] victim;
  logic                       accept;
  logic                       evict;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // zero acts as one frame; frames past the chain simply do not exist
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      if (cfg_q == '0) begin
        in_use[i] = (i == 0);
      end else begin
        in_use[i] = (5'(i) < {1'b0, cfg_q});
      end
    end
  end

  always_comb begin
    tok0_d = '0;
    if (accept) begin
      tok0_d.valid = 1'b1;
      tok0_d.page  = req_i.page_number;
    end
  end

  assign tok[0] = tok0_q;

  for (genvar g = 0; g < FRAMES; g++) begin : g_cell
    lrupr_cell #(
      .CELL_IDX(g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .in_use_i(in_use[g]),
      .tok_i   (tok[g]),
      .tok_o   (tok[g+1]),
      .upd_i   (upd)
    );
  end

  assign last  = tok[FRAMES];
  assign evict = !last.hit_found && !last.empty_found;

  always_comb begin
    priority if (last.hit_found) begin
      victim = last.hit_idx;
    end else if (last.empty_found) begin
      victim = last.empty_idx;
    end else begin
      victim = last.best_idx;
    end
  end

  always_comb begin
    upd.en      = last.valid;
    upd.clear   = last.valid && eos_q;
    upd.hit     = last.hit_found;
    upd.idx     = victim;
    upd.limit   = last.hit_rank;
    upd.age_all = !last.hit_found;
    upd.page    = last.page;
  end

  always_comb begin
    rsp_d.hit           = last.hit_found;
    rsp_d.frame_index   = lrupr_pkg::FrameIdxW'(victim);
    rsp_d.evicted_valid = evict;
    rsp_d.evicted_page  = evict ? last.best_page : '0;
    done_d              = last.valid;
    busy_d              = busy_q;
    eos_d               = eos_q;
    if (accept) begin
      busy_d = 1'b1;
      eos_d  = req_i.end_of_string;
    end else if (last.valid) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= lrupr_pkg::CfgReset;
      busy_q <= 1'b0;
      eos_q  <= 1'b0;
      done_q <= 1'b0;
      tok0_q <= '0;
    end else begin
      if (cfg_we_i) begin
        cfg_q <= cfg_wdata_i;
      end
      busy_q <= busy_d;
      eos_q  <= eos_d;
      done_q <= done_d;
      tok0_q <= tok0_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last.valid) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

`ifndef SYNTHESIS
  logic [FRAMES:0] tok_valid;
  always_comb begin
    for (int i = 0; i <= FRAMES; i++) begin
      tok_valid[i] = tok[i].valid;
    end
  end

  a_one_word_in_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_valid))
    else $error("more than one search word in the cell chain");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while an item is still in flight");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy && !done_o))
    else $error("accepted item did not mark the block busy");

  a_hit_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && rsp_o.hit) |-> !rsp_o.evicted_valid)
    else $error("hit reported with an eviction");

  a_evict_page_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !rsp_o.evicted_valid) |-> (rsp_o.evicted_page == '0))
    else $error("evicted page nonzero without eviction");
`endif

endmodule
